### src/gca_pkg.sv
// shared constants, codes and types for the grid cell ground adjacency block
// no dependencies
package gca_pkg;

    localparam int GRID_X = 256;
    localparam int GRID_Y = 256;
    localparam int GX_W   = $clog2(GRID_X);
    localparam int GY_W   = $clog2(GRID_Y);

    localparam int CMD_W      = 2;
    localparam int COORD_W    = 18;
    localparam int CELL_W     = 8;
    localparam int RADIUS_W   = 17;
    localparam int SCALE_W    = 24;
    localparam int THR_W      = 4;
    localparam int FRAC_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int NB_N       = 8;

    localparam logic [CMD_W-1:0] CMD_START    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLASSIFY = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE     = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THR    = 2'd2;

    localparam logic [RADIUS_W-1:0] RADIUS_RST = 17'd20000;
    localparam logic [SCALE_W-1:0]  SCALE_RST  = 24'd419430;
    localparam logic [THR_W-1:0]    THR_RST    = 4'd2;

    typedef struct packed {
        logic [GX_W-1:0] cell_x;
        logic [GY_W-1:0] cell_y;
        logic            in_range;
        logic            edge_cell;
    } loc_t;

endpackage

### src/grid_cell_ground_adjacency.sv
// top level: occupancy bitmap in a row ram, command sequencer, neighbour count, output register
// depends on gca_pkg, gca_row_ram, gca_locate
//
//   channel  handshake            beat
//   in       in_valid / in_stall  cmd, point_x_mm, point_y_mm
//   out      out_valid / out_stall cell_x, cell_y, in_range, edge_cell, ground_adjacent
//   cfg      cfg_we               cfg_index, cfg_wdata
//
// one item at a time; an item enters only when the sequencer is idle
// an in-range insert reads and writes back its row; an in-range classify off the border reads three rows and counts
// after its result, start clears all GRID_Y rows of the row ram, one row a cycle; reset runs the same sweep
// a result held by out_stall parks in the output register, the next item is still taken
module grid_cell_ground_adjacency (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic        [gca_pkg::CMD_W-1:0]      cmd,
    input  logic signed [gca_pkg::COORD_W-1:0]    point_x_mm,
    input  logic signed [gca_pkg::COORD_W-1:0]    point_y_mm,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic        [gca_pkg::CELL_W-1:0]     cell_x,
    output logic        [gca_pkg::CELL_W-1:0]     cell_y,
    output logic                                  in_range,
    output logic                                  edge_cell,
    output logic                                  ground_adjacent,
    input  logic                                  cfg_we,
    input  logic        [gca_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic        [gca_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import gca_pkg::*;

    localparam logic [3:0] ST_CLEAR   = 4'd0;
    localparam logic [3:0] ST_IDLE    = 4'd1;
    localparam logic [3:0] ST_CALC    = 4'd2;
    localparam logic [3:0] ST_RD_INS  = 4'd3;
    localparam logic [3:0] ST_WB      = 4'd4;
    localparam logic [3:0] ST_RD_UP   = 4'd5;
    localparam logic [3:0] ST_RD_MID  = 4'd6;
    localparam logic [3:0] ST_RD_DN   = 4'd7;
    localparam logic [3:0] ST_RD_LAST = 4'd8;
    localparam logic [3:0] ST_COUNT   = 4'd9;
    localparam logic [3:0] ST_DONE    = 4'd10;

    logic [3:0]          state_reg,  state_next;
    logic [GY_W-1:0]     clr_row_reg, clr_row_next;
    logic [RADIUS_W-1:0] radius_reg, radius_next;
    logic [SCALE_W-1:0]  scale_reg,  scale_next;
    logic [THR_W-1:0]    thr_reg,    thr_next;
    logic                out_valid_reg, out_valid_next;

    logic [CMD_W-1:0]    cmd_reg,  cmd_next;
    loc_t                loc_reg,  loc_next;
    logic [2:0]          win_up_reg,  win_up_next;
    logic [2:0]          win_mid_reg, win_mid_next;
    logic [2:0]          win_dn_reg,  win_dn_next;
    logic                gadj_reg, gadj_next;
    logic [CELL_W-1:0]   out_cx_reg, out_cx_next;
    logic [CELL_W-1:0]   out_cy_reg, out_cy_next;
    logic                out_inr_reg, out_inr_next;
    logic                out_edge_reg, out_edge_next;
    logic                out_gadj_reg, out_gadj_next;

    loc_t                loc_in;
    logic                accept;
    logic                ram_we;
    logic [GY_W-1:0]     ram_waddr;
    logic [GRID_X-1:0]   ram_wdata;
    logic                ram_re;
    logic [GY_W-1:0]     ram_raddr;
    logic [GRID_X-1:0]   ram_rdata;
    logic [GX_W-1:0]     col_lo;
    logic [2:0]          win;
    logic [GRID_X-1:0]   row_set;
    logic [NB_N-1:0]     nb;
    logic [THR_W-1:0]    occ_cnt;
    logic [THR_W-1:0]    free_cnt;

    assign accept   = in_valid && !in_stall;
    assign in_stall = state_reg != ST_IDLE;

    gca_locate u_locate (
        .clk        (clk),
        .load       (accept),
        .point_x_mm (point_x_mm),
        .point_y_mm (point_y_mm),
        .radius     (radius_reg),
        .scale      (scale_reg),
        .loc        (loc_in)
    );

    gca_row_ram #(
        .DEPTH (GRID_Y),
        .WIDTH (GRID_X)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // three-cell window around the column from the row just read
    assign col_lo = loc_reg.cell_x - GX_W'(1);
    assign win    = ram_rdata[col_lo +: 3];

    always_comb
    begin
        row_set                 = ram_rdata;
        row_set[loc_reg.cell_x] = 1'b1;
    end

    assign nb = {win_up_reg, win_mid_reg[2], win_mid_reg[0], win_dn_reg};

    always_comb
    begin
        occ_cnt = '0;
        for (int i = 0; i < NB_N; i++)
        begin
            occ_cnt = occ_cnt + THR_W'(nb[i]);
        end
        free_cnt = THR_W'(NB_N) - occ_cnt;
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = loc_reg.cell_y;
        ram_wdata = row_set;
        ram_re    = 1'b0;
        ram_raddr = loc_reg.cell_y;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_row_reg;
                ram_wdata = '0;
            end
            ST_WB:
            begin
                ram_we = 1'b1;
            end
            ST_RD_INS, ST_RD_MID:
            begin
                ram_re = 1'b1;
            end
            ST_RD_UP:
            begin
                ram_re    = 1'b1;
                ram_raddr = loc_reg.cell_y - GY_W'(1);
            end
            ST_RD_DN:
            begin
                ram_re    = 1'b1;
                ram_raddr = loc_reg.cell_y + GY_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_row_next   = clr_row_reg;
        radius_next    = radius_reg;
        scale_next     = scale_reg;
        thr_next       = thr_reg;
        out_valid_next = out_valid_reg;
        cmd_next       = cmd_reg;
        loc_next       = loc_reg;
        win_up_next    = win_up_reg;
        win_mid_next   = win_mid_reg;
        win_dn_next    = win_dn_reg;
        gadj_next      = gadj_reg;
        out_cx_next    = out_cx_reg;
        out_cy_next    = out_cy_reg;
        out_inr_next   = out_inr_reg;
        out_edge_next  = out_edge_reg;
        out_gadj_next  = out_gadj_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RADIUS: radius_next = cfg_wdata[RADIUS_W-1:0];
                REG_SCALE:  scale_next  = cfg_wdata[SCALE_W-1:0];
                REG_THR:    thr_next    = cfg_wdata[THR_W-1:0];
                default:
                begin
                end
            endcase
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_row_reg == GY_W'(GRID_Y - 1))
                begin
                    clr_row_next = '0;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    clr_row_next = clr_row_reg + GY_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = cmd;
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                gadj_next  = 1'b0;
                loc_next   = '0;
                state_next = ST_DONE;
                case (cmd_reg) inside
                    CMD_INSERT:
                    begin
                        loc_next = loc_in;
                        if (loc_in.in_range)
                        begin
                            state_next = ST_RD_INS;
                        end
                    end
                    CMD_CLASSIFY:
                    begin
                        loc_next = loc_in;
                        if (loc_in.in_range && !loc_in.edge_cell)
                        begin
                            state_next = ST_RD_UP;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_RD_INS:
            begin
                state_next = ST_WB;
            end
            ST_WB:
            begin
                state_next = ST_DONE;
            end
            ST_RD_UP:
            begin
                state_next = ST_RD_MID;
            end
            ST_RD_MID:
            begin
                win_up_next = win;
                state_next  = ST_RD_DN;
            end
            ST_RD_DN:
            begin
                win_mid_next = win;
                state_next   = ST_RD_LAST;
            end
            ST_RD_LAST:
            begin
                win_dn_next = win;
                state_next  = ST_COUNT;
            end
            ST_COUNT:
            begin
                gadj_next  = free_cnt >= thr_reg;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_cx_next    = CELL_W'(loc_reg.cell_x);
                    out_cy_next    = CELL_W'(loc_reg.cell_y);
                    out_inr_next   = loc_reg.in_range;
                    out_edge_next  = loc_reg.edge_cell;
                    out_gadj_next  = gadj_reg;
                    state_next     = (cmd_reg == CMD_START) ? ST_CLEAR : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_row_reg   <= '0;
            radius_reg    <= RADIUS_RST;
            scale_reg     <= SCALE_RST;
            thr_reg       <= THR_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_row_reg   <= clr_row_next;
            radius_reg    <= radius_next;
            scale_reg     <= scale_next;
            thr_reg       <= thr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        loc_reg      <= loc_next;
        win_up_reg   <= win_up_next;
        win_mid_reg  <= win_mid_next;
        win_dn_reg   <= win_dn_next;
        gadj_reg     <= gadj_next;
        out_cx_reg   <= out_cx_next;
        out_cy_reg   <= out_cy_next;
        out_inr_reg  <= out_inr_next;
        out_edge_reg <= out_edge_next;
        out_gadj_reg <= out_gadj_next;
    end

    assign out_valid       = out_valid_reg;
    assign cell_x          = out_cx_reg;
    assign cell_y          = out_cy_reg;
    assign in_range        = out_inr_reg;
    assign edge_cell       = out_edge_reg;
    assign ground_adjacent = out_gadj_reg;

`ifndef SYNTH
    a_gadj_needs_inner_cell: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!ground_adjacent || (in_range && !edge_cell)))
        else $error("ground_adjacent set for a border or out of range cell");

    a_out_of_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !in_range) |-> (cell_x == '0 && cell_y == '0 && !edge_cell))
        else $error("out of range beat carries a cell");

    a_start_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && cmd == CMD_START) |=> ##1 in_stall)
        else $error("input taken during start scan");

    a_no_write_while_reading: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> !ram_we)
        else $error("bitmap read and write in the same cycle");
`endif

endmodule

### src/gca_row_ram.sv
// simple dual port ram, one write and one registered read per cycle
// no dependencies
module gca_row_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### src/gca_locate.sv
// range test and cell binning: squares and scaled offsets registered, then compare and clamp
// depends on gca_pkg
module gca_locate (
    input  logic                                clk,
    input  logic                                load,
    input  logic signed [gca_pkg::COORD_W-1:0]  point_x_mm,
    input  logic signed [gca_pkg::COORD_W-1:0]  point_y_mm,
    input  logic        [gca_pkg::RADIUS_W-1:0] radius,
    input  logic        [gca_pkg::SCALE_W-1:0]  scale,
    output gca_pkg::loc_t                       loc
);
    import gca_pkg::*;

    localparam int SQ_W   = 2 * COORD_W;
    localparam int R2_W   = 2 * RADIUS_W;
    localparam int PROD_W = COORD_W + SCALE_W;
    localparam int IDX_W  = PROD_W - FRAC_W;

    logic signed [SQ_W-1:0]    sqx_full;
    logic signed [SQ_W-1:0]    sqy_full;
    logic signed [COORD_W:0]   offx_full;
    logic signed [COORD_W:0]   offy_full;
    logic [COORD_W-1:0]        offx;
    logic [COORD_W-1:0]        offy;
    logic [PROD_W-1:0]         px_next;
    logic [PROD_W-1:0]         py_next;
    logic [R2_W-1:0]           r2_next;

    logic [SQ_W-2:0]           sqx_reg;
    logic [SQ_W-2:0]           sqy_reg;
    logic [PROD_W-1:0]         px_reg;
    logic [PROD_W-1:0]         py_reg;
    logic [R2_W-1:0]           r2_reg;

    logic [SQ_W-1:0]           d2;
    logic                      inr;
    logic [IDX_W-1:0]          idx_x;
    logic [IDX_W-1:0]          idx_y;
    logic [GX_W-1:0]           cx;
    logic [GY_W-1:0]           cy;

    assign sqx_full  = point_x_mm * point_x_mm;
    assign sqy_full  = point_y_mm * point_y_mm;
    assign offx_full = {point_x_mm[COORD_W-1], point_x_mm} + $signed({2'b00, radius});
    assign offy_full = {point_y_mm[COORD_W-1], point_y_mm} + $signed({2'b00, radius});
    assign offx      = offx_full[COORD_W-1:0];
    assign offy      = offy_full[COORD_W-1:0];
    assign px_next   = PROD_W'(offx) * PROD_W'(scale);
    assign py_next   = PROD_W'(offy) * PROD_W'(scale);
    assign r2_next   = R2_W'(radius) * R2_W'(radius);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sqx_reg <= sqx_full[SQ_W-2:0];
            sqy_reg <= sqy_full[SQ_W-2:0];
            px_reg  <= px_next;
            py_reg  <= py_next;
            r2_reg  <= r2_next;
        end
    end

    assign d2    = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign inr   = d2 < SQ_W'(r2_reg);
    assign idx_x = px_reg[PROD_W-1:FRAC_W];
    assign idx_y = py_reg[PROD_W-1:FRAC_W];

    always_comb
    begin
        if (idx_x > IDX_W'(GRID_X - 1))
        begin
            cx = GX_W'(GRID_X - 1);
        end
        else
        begin
            cx = idx_x[GX_W-1:0];
        end
        if (idx_y > IDX_W'(GRID_Y - 1))
        begin
            cy = GY_W'(GRID_Y - 1);
        end
        else
        begin
            cy = idx_y[GY_W-1:0];
        end
    end

    always_comb
    begin
        loc = '0;
        if (inr)
        begin
            loc.cell_x    = cx;
            loc.cell_y    = cy;
            loc.in_range  = 1'b1;
            loc.edge_cell = (cx == '0) || (cx == GX_W'(GRID_X - 1)) ||
                            (cy == '0) || (cy == GY_W'(GRID_Y - 1));
        end
    end

endmodule
